FILE: sv/text_console_cursor_control_unit_macros.svh
// Assertion macros shared by the cursor control unit.
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCCU_ASSERT_HOLDS(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TCCU_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/tccu_pkg.sv
// Types, constants and microcode ROM of the text console cursor control unit.
package tccu_pkg;

    localparam int GLYPH_WIDTH    = 8;
    localparam int GLYPH_HEIGHT   = 16;
    localparam int TAB_STOP_CELLS = 8;
    localparam int MAX_TAB_SPACES = 9;

    localparam logic signed [27:0] GW_W   = 28'(GLYPH_WIDTH);
    localparam logic signed [27:0] GH_W   = 28'(GLYPH_HEIGHT);
    localparam logic signed [27:0] TAB_W  = 28'(TAB_STOP_CELLS);
    localparam logic signed [27:0] STOP_W = 28'(TAB_STOP_CELLS * GLYPH_WIDTH);
    localparam logic signed [23:0] GW_24  = 24'(GLYPH_WIDTH);
    localparam logic signed [23:0] GH_24  = 24'(GLYPH_HEIGHT);
    localparam logic [3:0]         MAX_N  = 4'(MAX_TAB_SPACES);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;
    localparam int CFG_W     = 13;

    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] ACT_PUT       = 2'd0;
    localparam logic [1:0] ACT_GOTO_PX   = 2'd1;
    localparam logic [1:0] ACT_GOTO_CELL = 2'd2;
    localparam logic [1:0] ACT_CLEAR     = 2'd3;

    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TEXT_COLUMNS  = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_GOTO_PX   = 4'd1;
    localparam logic [3:0] OP_GOTO_CELL = 4'd2;
    localparam logic [3:0] OP_CLEAR     = 4'd3;
    localparam logic [3:0] OP_CR        = 4'd4;
    localparam logic [3:0] OP_BS        = 4'd5;
    localparam logic [3:0] OP_TAB_Q     = 4'd6;
    localparam logic [3:0] OP_TAB_STOP  = 4'd7;
    localparam logic [3:0] OP_TAB_N     = 4'd8;
    localparam logic [3:0] OP_SET_ONE   = 4'd9;
    localparam logic [3:0] OP_GLYPH     = 4'd10;
    localparam logic [3:0] OP_LF        = 4'd11;
    localparam logic [3:0] OP_SCROLL    = 4'd12;

    // sequencer conditions
    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_ACCEPT   = 3'd1;
    localparam logic [2:0] C_DISPATCH = 3'd2;
    localparam logic [2:0] C_MORE     = 3'd3;
    localparam logic [2:0] C_WRAP     = 3'd4;

    // program steps
    localparam logic [4:0] U_IDLE     = 5'd0;
    localparam logic [4:0] U_DISP     = 5'd1;
    localparam logic [4:0] U_GPX      = 5'd2;
    localparam logic [4:0] U_GCELL    = 5'd3;
    localparam logic [4:0] U_CLR      = 5'd4;
    localparam logic [4:0] U_CR       = 5'd5;
    localparam logic [4:0] U_BS       = 5'd6;
    localparam logic [4:0] U_TAB_Q    = 5'd7;
    localparam logic [4:0] U_TAB_STOP = 5'd8;
    localparam logic [4:0] U_TAB_N    = 5'd9;
    localparam logic [4:0] U_PRINT    = 5'd10;
    localparam logic [4:0] U_GLYPH    = 5'd11;
    localparam logic [4:0] U_WRAP     = 5'd12;
    localparam logic [4:0] U_LF       = 5'd13;
    localparam logic [4:0] U_SCROLL   = 5'd14;
    localparam logic [4:0] U_LOOP     = 5'd15;
    localparam logic [4:0] U_END      = 5'd16;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [4:0] jump;
        logic [4:0] next;
    } ucode_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         code;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } item_t;

    typedef struct packed {
        logic [12:0] sw;
        logic [12:0] sh;
        logic [9:0]  tc;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [7:0]         glyph;
    } result_t;

    typedef struct packed {
        logic [3:0] op;
        logic       run;
    } ctl_t;

    typedef struct packed {
        logic    more;
        logic    wrap;
        logic    emit;
        result_t res;
    } sts_t;

    function automatic ucode_t ucode(input logic [4:0] upc);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, jump: U_IDLE, next: U_IDLE};
        unique case (upc)
            U_IDLE:     w = '{op: OP_NOP,       cond: C_ACCEPT,   jump: U_DISP,  next: U_IDLE};
            U_DISP:     w = '{op: OP_NOP,       cond: C_DISPATCH, jump: U_IDLE,  next: U_IDLE};
            U_GPX:      w = '{op: OP_GOTO_PX,   cond: C_ALWAYS,   jump: U_END,   next: U_END};
            U_GCELL:    w = '{op: OP_GOTO_CELL, cond: C_ALWAYS,   jump: U_END,   next: U_END};
            U_CLR:      w = '{op: OP_CLEAR,     cond: C_ALWAYS,   jump: U_END,   next: U_END};
            U_CR:       w = '{op: OP_CR,        cond: C_ALWAYS,   jump: U_END,   next: U_END};
            U_BS:       w = '{op: OP_BS,        cond: C_ALWAYS,   jump: U_END,   next: U_END};
            U_TAB_Q:    w = '{op: OP_TAB_Q,     cond: C_ALWAYS,   jump: U_TAB_STOP,
                              next: U_TAB_STOP};
            U_TAB_STOP: w = '{op: OP_TAB_STOP,  cond: C_ALWAYS,   jump: U_TAB_N, next: U_TAB_N};
            U_TAB_N:    w = '{op: OP_TAB_N,     cond: C_ALWAYS,   jump: U_LOOP,  next: U_LOOP};
            U_PRINT:    w = '{op: OP_SET_ONE,   cond: C_ALWAYS,   jump: U_GLYPH, next: U_GLYPH};
            U_GLYPH:    w = '{op: OP_GLYPH,     cond: C_ALWAYS,   jump: U_WRAP,  next: U_WRAP};
            U_WRAP:     w = '{op: OP_NOP,       cond: C_WRAP,     jump: U_LF,    next: U_LOOP};
            U_LF:       w = '{op: OP_LF,        cond: C_ALWAYS,   jump: U_SCROLL,
                              next: U_SCROLL};
            U_SCROLL:   w = '{op: OP_SCROLL,    cond: C_ALWAYS,   jump: U_LOOP,  next: U_LOOP};
            U_LOOP:     w = '{op: OP_NOP,       cond: C_MORE,     jump: U_GLYPH, next: U_END};
            U_END:      w = '{op: OP_NOP,       cond: C_ALWAYS,   jump: U_IDLE,  next: U_IDLE};
            default:    w = '{op: OP_NOP,       cond: C_ALWAYS,   jump: U_IDLE,  next: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/tccu_datapath.sv
// Cursor datapath: cursor, home, tab count and the operations the microcode selects.
module tccu_datapath (
    input  logic            aclk,
    input  logic            aresetn,
    input  tccu_pkg::ctl_t  ctl,
    input  tccu_pkg::item_t item,
    input  tccu_pkg::cfg_t  cfg,
    output tccu_pkg::sts_t  sts
);

    logic signed [23:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [23:0] hx_reg, hx_next, hy_reg, hy_next;
    logic signed [27:0] t_reg, t_next;
    logic [3:0]         n_reg, n_next;

    logic signed [27:0] x_w, y_w, tc_px, sh_lim, q_up, n_div;
    logic signed [23:0] in_x, in_y, w_px, h_px, px_x, px_y, bs_x, bs_wrap_x;
    logic               scroll_due;
    logic [7:0]         glyph;

    assign x_w        = {{4{cx_reg[23]}}, cx_reg};
    assign y_w        = {{4{cy_reg[23]}}, cy_reg};
    assign tc_px      = $signed({18'd0, cfg.tc}) * tccu_pkg::GW_W;
    assign sh_lim     = $signed({15'd0, cfg.sh}) - tccu_pkg::GH_W;
    assign scroll_due = y_w > sh_lim;
    assign q_up       = (t_reg + 28'sd1) / tccu_pkg::TAB_W;
    assign n_div      = (t_reg - x_w) / tccu_pkg::GW_W;

    assign in_x = {{8{item.cx[15]}}, item.cx};
    assign in_y = {{8{item.cy[15]}}, item.cy};
    assign w_px = {11'd0, cfg.sw};
    assign h_px = {11'd0, cfg.sh};
    assign px_x = in_x[23] ? 24'sd0 : ((in_x >= w_px) ? (w_px - 24'sd1) : in_x);
    assign px_y = in_y[23] ? 24'sd0 : ((in_y >= h_px) ? (h_px - 24'sd1) : in_y);

    assign bs_x      = cx_reg - tccu_pkg::GW_24;
    assign bs_wrap_x = ($signed({14'd0, cfg.tc}) - 24'sd1) * tccu_pkg::GW_24;

    assign glyph = (item.code == tccu_pkg::CHAR_TAB) ? tccu_pkg::CHAR_SPACE : item.code;

    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        hx_next = hx_reg;
        hy_next = hy_reg;
        t_next  = t_reg;
        n_next  = n_reg;
        sts.more      = n_reg != 4'd0;
        sts.wrap      = x_w > tc_px;
        sts.emit      = 1'b0;
        sts.res.cmd   = tccu_pkg::CMD_DRAW;
        sts.res.x     = cx_reg;
        sts.res.y     = cy_reg;
        sts.res.glyph = glyph;
        unique case (ctl.op)
            tccu_pkg::OP_NOP: begin
            end
            tccu_pkg::OP_GOTO_PX: begin
                cx_next = px_x;
                cy_next = px_y;
            end
            tccu_pkg::OP_GOTO_CELL: begin
                cx_next = in_x * tccu_pkg::GW_24;
                cy_next = in_y * tccu_pkg::GH_24;
                hx_next = in_x * tccu_pkg::GW_24;
                hy_next = in_y * tccu_pkg::GH_24;
            end
            tccu_pkg::OP_CLEAR: begin
                sts.emit      = 1'b1;
                sts.res.cmd   = tccu_pkg::CMD_CLEAR;
                sts.res.x     = '0;
                sts.res.y     = '0;
                sts.res.glyph = '0;
                cx_next = hx_reg;
                cy_next = hy_reg;
            end
            tccu_pkg::OP_CR: begin
                cx_next = '0;
            end
            tccu_pkg::OP_BS: begin
                if (!bs_x[23]) begin
                    cx_next = bs_x;
                end else if (cy_reg > 24'sd0) begin
                    cx_next = bs_wrap_x;
                    cy_next = cy_reg - tccu_pkg::GH_24;
                end else begin
                    cx_next = '0;
                end
            end
            tccu_pkg::OP_TAB_Q: begin
                t_next = x_w / tccu_pkg::GW_W;
            end
            tccu_pkg::OP_TAB_STOP: begin
                t_next = (q_up + 28'sd1) * tccu_pkg::STOP_W;
            end
            tccu_pkg::OP_TAB_N: begin
                if (n_div <= 28'sd0) begin
                    n_next = '0;
                end else if (n_div > $signed({24'd0, tccu_pkg::MAX_N})) begin
                    n_next = tccu_pkg::MAX_N;
                end else begin
                    n_next = n_div[3:0];
                end
            end
            tccu_pkg::OP_SET_ONE: begin
                n_next = 4'd1;
            end
            tccu_pkg::OP_GLYPH: begin
                sts.emit = 1'b1;
                cx_next  = cx_reg + tccu_pkg::GW_24;
                n_next   = n_reg - 4'd1;
            end
            tccu_pkg::OP_LF: begin
                cx_next = '0;
                cy_next = cy_reg + tccu_pkg::GH_24;
            end
            tccu_pkg::OP_SCROLL: begin
                if (scroll_due) begin
                    sts.emit      = 1'b1;
                    sts.res.cmd   = tccu_pkg::CMD_SCROLL;
                    sts.res.x     = '0;
                    sts.res.y     = '0;
                    sts.res.glyph = '0;
                    cy_next = cy_reg - tccu_pkg::GH_24;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0;
            cy_reg <= '0;
            hx_reg <= '0;
            hy_reg <= '0;
            n_reg  <= '0;
        end else if (ctl.run) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            hx_reg <= hx_next;
            hy_reg <= hy_next;
            n_reg  <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.run) begin
            t_reg <= t_next;
        end
    end

endmodule

FILE: sv/text_console_cursor_control_unit.sv
// Text console cursor control unit: microcoded sequencer, config and output stage.
// Usage:
//   s_* carries one request per item: s_tuser = action, s_tdata = char_code,
//   coord_x, coord_y. m_* carries the draw, scroll and clear commands it causes:
//   m_tuser = command, m_tdata = draw_x, draw_y, glyph_code, m_tlast marks the
//   final command of a request. Requests that cause no command produce nothing.
//   cfg_wr_en/cfg_index/cfg_data write screen_width, screen_height and
//   text_columns; write them only while the unit is idle.
// Sequencing: a ROM program, one step per cycle while not stalled, handles one
//   request at a time; a tab prints at most 9 spaces, each of which may wrap to a
//   new line. A command leaves the pending register when the next one is produced
//   or the program reaches its end step.
// Reset: cursor and home go to 0, registers to 640 x 480 pixels, 80 columns.
// Stall: the last command waits in a pending register, the previous one in the
//   output register; with both full the program holds until m_tready.
`include "text_console_cursor_control_unit_macros.svh"

module text_console_cursor_control_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tccu_pkg::S_TDATA_W-1:0]   s_tdata,   // char_code, coord_x, coord_y
    input  logic [1:0]                       s_tuser,   // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tccu_pkg::M_TDATA_W-1:0]   m_tdata,   // draw_x, draw_y, glyph_code
    output logic [1:0]                       m_tuser,   // command
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic [tccu_pkg::CFG_W-1:0]       cfg_data
);

    logic [4:0]        upc_reg, upc_next, disp_target;
    tccu_pkg::ucode_t  uw;
    tccu_pkg::item_t   item_reg;
    tccu_pkg::cfg_t    cfg_reg;
    tccu_pkg::ctl_t    ctl;
    tccu_pkg::sts_t    sts;
    tccu_pkg::result_t pend_reg, out_reg;
    logic              pend_valid_reg, out_valid_reg, out_last_reg;
    logic              slot_free, at_end, stall, push;

    assign uw        = tccu_pkg::ucode(upc_reg);
    assign at_end    = upc_reg == tccu_pkg::U_END;
    assign slot_free = !out_valid_reg || m_tready;
    assign stall     = (sts.emit || at_end) && pend_valid_reg && !slot_free;
    assign push      = !stall && (sts.emit || at_end) && pend_valid_reg;

    assign ctl.op  = uw.op;
    assign ctl.run = !stall;

    assign s_tready = upc_reg == tccu_pkg::U_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.glyph, out_reg.y, out_reg.x};
    assign m_tuser  = out_reg.cmd;
    assign m_tlast  = out_last_reg;

    tccu_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .sts     (sts)
    );

    always_comb begin
        disp_target = tccu_pkg::U_END;
        unique case (item_reg.action)
            tccu_pkg::ACT_PUT: begin
                unique case (item_reg.code)
                    tccu_pkg::CHAR_CR:  disp_target = tccu_pkg::U_CR;
                    tccu_pkg::CHAR_LF:  disp_target = tccu_pkg::U_LF;
                    tccu_pkg::CHAR_BS:  disp_target = tccu_pkg::U_BS;
                    tccu_pkg::CHAR_TAB: disp_target = tccu_pkg::U_TAB_Q;
                    default:            disp_target = tccu_pkg::U_PRINT;
                endcase
            end
            tccu_pkg::ACT_GOTO_PX:   disp_target = tccu_pkg::U_GPX;
            tccu_pkg::ACT_GOTO_CELL: disp_target = tccu_pkg::U_GCELL;
            tccu_pkg::ACT_CLEAR:     disp_target = tccu_pkg::U_CLR;
            default:                 disp_target = tccu_pkg::U_END;
        endcase
    end

    always_comb begin
        upc_next = uw.next;
        unique case (uw.cond)
            tccu_pkg::C_ALWAYS:   upc_next = uw.next;
            tccu_pkg::C_ACCEPT:   upc_next = s_tvalid ? uw.jump : uw.next;
            tccu_pkg::C_DISPATCH: upc_next = disp_target;
            tccu_pkg::C_MORE:     upc_next = sts.more ? uw.jump : uw.next;
            tccu_pkg::C_WRAP:     upc_next = sts.wrap ? uw.jump : uw.next;
            default:              upc_next = tccu_pkg::U_IDLE;
        endcase
        if (stall) begin
            upc_next = upc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg        <= tccu_pkg::U_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cfg_reg.sw     <= 13'd640;
            cfg_reg.sh     <= 13'd480;
            cfg_reg.tc     <= 10'd80;
        end else begin
            upc_reg <= upc_next;
            if (!stall && sts.emit) begin
                pend_valid_reg <= 1'b1;
            end else if (push) begin
                pend_valid_reg <= 1'b0;
            end
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tccu_pkg::REG_SCREEN_WIDTH:  cfg_reg.sw <= cfg_data;
                    tccu_pkg::REG_SCREEN_HEIGHT: cfg_reg.sh <= cfg_data;
                    tccu_pkg::REG_TEXT_COLUMNS:  cfg_reg.tc <= cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action <= s_tuser;
            item_reg.code   <= s_tdata[7:0];
            item_reg.cx     <= s_tdata[23:8];
            item_reg.cy     <= s_tdata[39:24];
        end
        if (!stall && sts.emit) begin
            pend_reg <= sts.res;
        end
        if (push) begin
            out_reg      <= pend_reg;
            out_last_reg <= at_end;
        end
    end

    `TCCU_ASSERT_HOLDS(a_idle_nothing_pending, s_tready, !pend_valid_reg, "pending result at idle")
    `TCCU_ASSERT_NEXT(a_pending_kept, pend_valid_reg && !slot_free, pend_valid_reg, "pending lost")
    `TCCU_ASSERT_NEXT(a_accept_dispatch, s_tvalid && s_tready,
                      upc_reg == tccu_pkg::U_DISP, "accept did not dispatch")

endmodule
